### design/cwb_pkg.sv
// ----------------------------------------------------------------------------
// cwb_pkg: shared types for the coalescing write buffer
// Operation and status codes, entry and broadcast command structs.
// ----------------------------------------------------------------------------
package cwb_pkg;

    localparam int DATA_W = 64;

    // operation codes carried on i_mode
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_UPDATE = 2'd1,
        OP_REMOVE = 2'd2,
        OP_LOOKUP = 2'd3
    } t_op;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_MISS  = 2'd3
    } t_status;

    // one buffered entry, as handed from cell to cell
    typedef struct packed {
        logic              valid;
        logic [DATA_W-1:0] addr;
        logic [DATA_W-1:0] epoch;
    } t_entry;

    // command broadcast to every cell
    typedef struct packed {
        logic              shift;
        logic              append;
        logic              wr_epoch;
        logic [DATA_W-1:0] key;
        logic [DATA_W-1:0] epoch;
    } t_cmd;

endpackage

### design/cwb_cell.sv
// ----------------------------------------------------------------------------
// cwb_cell: one slot of the shifting write buffer
// Holds one entry, compares it against the broadcast key, takes its upper
// neighbor's entry on a drain and joins the youngest-match priority chain.
// ----------------------------------------------------------------------------
module cwb_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  cwb_pkg::t_cmd   i_cmd,
    input  logic            i_tail,
    input  logic            i_up_hit,
    input  cwb_pkg::t_entry i_next,
    output cwb_pkg::t_entry o_entry,
    output logic            o_hit
);
    import cwb_pkg::*;

    logic              r_valid;
    logic [DATA_W-1:0] r_addr;
    logic [DATA_W-1:0] r_epoch;
    logic              w_match;
    logic              w_take;

    // address compare and youngest-match priority
    assign w_match = r_valid && (r_addr == i_cmd.key);
    assign w_take  = w_match && !i_up_hit;
    assign o_hit   = w_match || i_up_hit;

    assign o_entry = '{valid: r_valid, addr: r_addr, epoch: r_epoch};

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.shift) begin
            r_valid <= i_next.valid;
        end else if (i_cmd.append && i_tail) begin
            r_valid <= 1'b1;
        end
    end

    // entry payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.shift) begin
            r_addr  <= i_next.addr;
            r_epoch <= i_next.epoch;
        end else if (i_cmd.append && i_tail) begin
            r_addr  <= i_cmd.key;
            r_epoch <= i_cmd.epoch;
        end else if (i_cmd.wr_epoch && w_take) begin
            r_epoch <= i_cmd.epoch;
        end
    end

endmodule

### design/coalescing_write_buffer_top.sv
// ----------------------------------------------------------------------------
// coalescing_write_buffer_top: FIFO write buffer with address lookup
// A row of cells, oldest entry in cell 0; drains shift the row down by one.
// ----------------------------------------------------------------------------
// Usage:
//   A command beat (i_mode, i_address, i_epoch_id) is taken on a clock edge
//   with start high and busy low. busy is never raised, so one command can
//   be issued every cycle. Modes: insert, update, remove oldest, lookup.
//   Each command gives exactly one result beat, on the cycle after it is
//   taken: o_strobe is high for that one cycle with o_out_address,
//   o_out_epoch_id, o_present, o_status and o_occupancy. Throughput is
//   one command per cycle; the path is set by the parallel 64-bit
//   compare in every cell and the youngest-match chain running down the
//   row of DEPTH cells.
//   The receiver cannot stall, so results are never held.
//   i_cfg_we / i_cfg_wdata write the coalesce enable bit; write it only
//   while no command is in flight.
//   Reset (synchronous, active low) empties the buffer and sets coalescing
//   on; there is no clearing pass, the buffer is usable right after reset.
// ----------------------------------------------------------------------------
module coalescing_write_buffer_top #(
    parameter int DEPTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   i_mode,
    input  logic [cwb_pkg::DATA_W-1:0]   i_address,
    input  logic [cwb_pkg::DATA_W-1:0]   i_epoch_id,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_wdata,
    output logic                         o_strobe,
    output logic [cwb_pkg::DATA_W-1:0]   o_out_address,
    output logic [cwb_pkg::DATA_W-1:0]   o_out_epoch_id,
    output logic                         o_present,
    output logic [1:0]                   o_status,
    output logic [$clog2(DEPTH+1)-1:0]   o_occupancy
);
    import cwb_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    logic              r_coalesce;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;
    logic              r_strobe;
    logic [DATA_W-1:0] r_out_addr;
    logic [DATA_W-1:0] r_out_epoch;
    logic              r_present;
    t_status           r_status;
    logic [CW-1:0]     r_occ;

    logic              w_accept;
    logic              w_full;
    logic              w_empty;
    logic              w_any_hit;
    t_cmd              w_cmd;
    t_status           w_status;
    logic              w_present;
    logic [DATA_W-1:0] w_out_addr;
    logic [DATA_W-1:0] w_out_epoch;
    t_entry            w_ent [DEPTH+1];
    logic              w_hit [DEPTH+1];
    logic [DEPTH-1:0]  w_valid_vec;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;
    assign w_full   = (r_count == CW'(DEPTH));
    assign w_empty  = (r_count == '0);

    // row ends: nothing above the youngest cell
    assign w_ent[DEPTH] = '0;
    assign w_hit[DEPTH] = 1'b0;
    assign w_any_hit    = w_hit[0];

    // row of entry cells
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        cwb_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_cmd    (w_cmd),
            .i_tail   (r_count == CW'(gi)),
            .i_up_hit (w_hit[gi+1]),
            .i_next   (w_ent[gi+1]),
            .o_entry  (w_ent[gi]),
            .o_hit    (w_hit[gi])
        );
        assign w_valid_vec[gi] = w_ent[gi].valid;
    end

    // command decode
    always_comb begin
        w_cmd       = '{shift: 1'b0, append: 1'b0, wr_epoch: 1'b0,
                        key: i_address, epoch: i_epoch_id};
        n_count     = r_count;
        w_status    = ST_OK;
        w_present   = 1'b0;
        w_out_addr  = '0;
        w_out_epoch = '0;
        if (w_accept) begin
            case (t_op'(i_mode))
                OP_INSERT: begin
                    w_present = w_any_hit;
                    if (r_coalesce && w_any_hit) begin
                        w_cmd.wr_epoch = 1'b1;
                    end else if (w_full) begin
                        w_status = ST_FULL;
                    end else begin
                        w_cmd.append = 1'b1;
                        n_count      = r_count + CW'(1);
                    end
                end
                OP_UPDATE: begin
                    if (w_any_hit) begin
                        w_present      = 1'b1;
                        w_cmd.wr_epoch = 1'b1;
                    end else begin
                        w_status = ST_MISS;
                    end
                end
                OP_REMOVE: begin
                    if (w_empty) begin
                        w_status = ST_EMPTY;
                    end else begin
                        w_cmd.shift = 1'b1;
                        w_out_addr  = w_ent[0].addr;
                        w_out_epoch = w_ent[0].epoch;
                        n_count     = r_count - CW'(1);
                    end
                end
                OP_LOOKUP: begin
                    w_present = w_any_hit;
                end
                default: begin
                    w_status = ST_OK;
                end
            endcase
        end
    end

    // control state: config bit, fill count, result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coalesce <= 1'b1;
            r_count    <= '0;
            r_strobe   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_coalesce <= i_cfg_wdata;
            end
            r_count  <= n_count;
            r_strobe <= w_accept;
        end
    end

    // result beat payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_addr  <= w_out_addr;
            r_out_epoch <= w_out_epoch;
            r_present   <= w_present;
            r_status    <= w_status;
            r_occ       <= n_count;
        end
    end

    assign o_strobe       = r_strobe;
    assign o_out_address  = r_out_addr;
    assign o_out_epoch_id = r_out_epoch;
    assign o_present      = r_present;
    assign o_status       = r_status;
    assign o_occupancy    = r_occ;

    // fill count never passes the row length
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("fill count above depth");

    // valid cells always match the fill count
    a_valid_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid_vec) == int'(r_count))
        else $error("cell valid bits disagree with fill count");

    // every accepted command gives one result beat next cycle
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_strobe)
        else $error("missing result beat");

    // a full flag only when the buffer is full
    a_full_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status == ST_FULL) |-> (o_occupancy == CW'(DEPTH)))
        else $error("full status with free slots");

endmodule
